### hdl/aar_pkg.sv
// ----------------------------------------------------------------------------
// aar_pkg
// Shared types and constants for the axis-angle rotation matrix pipeline.
// ----------------------------------------------------------------------------
package aar_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 24;

    typedef logic signed [33:0] q30_t;
    typedef logic signed [17:0] elem_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    localparam q30_t  Q30_ONE         = 34'sd1073741824;
    localparam q30_t  CORDIC_INV_GAIN = 34'sd652032874;
    localparam elem_t OUT_MAX         = 18'sd65536;

    // arctangent of 2^-i, 2^32 per turn
    localparam logic [31:0] ATAN_TAB [CORDIC_MAX] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

### hdl/axis_angle_rotation_matrix.sv
// An accepted input word passes the input, square, square root, divider, sign, product and output registers.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output register is full and stalled.
// Stage count is set by the 32-step square root and the 31-step divider.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rodrigues 3x3 rotation matrix from a binary angle and a Q2.14 axis:
// pipelined CORDIC, square root, divider and multiplier stages.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STAGES = aar_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         angle,
    input  logic signed [15:0]  axis_x,
    input  logic signed [15:0]  axis_y,
    input  logic signed [15:0]  axis_z,
    output logic                out_valid,
    input  logic                out_stall,
    output aar_pkg::elem_t      r00,
    output aar_pkg::elem_t      r01,
    output aar_pkg::elem_t      r02,
    output aar_pkg::elem_t      r10,
    output aar_pkg::elem_t      r11,
    output aar_pkg::elem_t      r12,
    output aar_pkg::elem_t      r20,
    output aar_pkg::elem_t      r21,
    output aar_pkg::elem_t      r22,
    output logic                zero_axis
);
    import aar_pkg::*;

    localparam int NC   = (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;
    localparam int SQ_N = 32;
    localparam int DV_N = 31;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [67:0] p;
        p = a * b + (68'sd1 <<< 29);
        return p[63:30];
    endfunction

    function automatic elem_t to_out(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (v + 36'sd8192) >>> 14;
        if (t > 36'sd65536)
            return OUT_MAX;
        else if (t < -36'sd65536)
            return -OUT_MAX;
        else
            return t[17:0];
    endfunction

    // output register
    logic  out_valid_reg, zero_axis_reg;
    elem_t r00_reg, r01_reg, r02_reg, r10_reg, r11_reg, r12_reg, r20_reg, r21_reg, r22_reg;

    logic en;
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // input and square stages
    logic               v0_reg, v1_reg;
    logic [15:0]        ang0_reg, ang1_reg;
    logic signed [15:0] ax0_reg, ay0_reg, az0_reg;
    logic signed [15:0] ax1_reg, ay1_reg, az1_reg;
    logic [30:0]        sqx1_reg, sqy1_reg, sqz1_reg;
    logic signed [31:0] px, py, pz;
    logic [31:0]        n2_sum;

    assign px     = ax0_reg * ax0_reg;
    assign py     = ay0_reg * ay0_reg;
    assign pz     = az0_reg * az0_reg;
    assign n2_sum = 32'(sqx1_reg) + 32'(sqy1_reg) + 32'(sqz1_reg);

    // square root stages
    logic               sq_v_reg    [0:SQ_N];
    logic               sq_zero_reg [0:SQ_N];
    logic [63:0]        sq_op_reg   [0:SQ_N];
    logic [63:0]        sq_res_reg  [0:SQ_N];
    logic [15:0]        sq_ang_reg  [0:SQ_N];
    logic signed [15:0] sq_ax_reg   [0:SQ_N];
    logic signed [15:0] sq_ay_reg   [0:SQ_N];
    logic signed [15:0] sq_az_reg   [0:SQ_N];
    logic [63:0]        sq_op_next  [0:SQ_N-1];
    logic [63:0]        sq_res_next [0:SQ_N-1];

    always_comb
    begin
        logic [63:0] one_k;
        logic [64:0] trial;
        for (int k = 0; k < SQ_N; k++)
        begin
            one_k = 64'd1 << (62 - 2 * k);
            trial = {1'b0, sq_res_reg[k]} + {1'b0, one_k};
            if ({1'b0, sq_op_reg[k]} >= trial)
            begin
                sq_op_next[k]  = sq_op_reg[k] - trial[63:0];
                sq_res_next[k] = (sq_res_reg[k] >> 1) + one_k;
            end
            else
            begin
                sq_op_next[k]  = sq_op_reg[k];
                sq_res_next[k] = sq_res_reg[k] >> 1;
            end
        end
    end

    // divider stages, CORDIC rides along in the first NC of them
    logic [31:0] len;
    assign len = sq_res_reg[SQ_N][31:0];

    logic               dv_v_reg    [0:DV_N];
    logic               dv_zero_reg [0:DV_N];
    logic [31:0]        dv_d_reg    [0:DV_N];
    logic [61:0]        dv_rx_reg   [0:DV_N];
    logic [61:0]        dv_ry_reg   [0:DV_N];
    logic [61:0]        dv_rz_reg   [0:DV_N];
    logic [30:0]        dv_qx_reg   [0:DV_N];
    logic [30:0]        dv_qy_reg   [0:DV_N];
    logic [30:0]        dv_qz_reg   [0:DV_N];
    logic               dv_sx_reg   [0:DV_N];
    logic               dv_sy_reg   [0:DV_N];
    logic               dv_sz_reg   [0:DV_N];
    quad_t              dv_quad_reg [0:DV_N];
    q30_t               dv_cx_reg   [0:DV_N];
    q30_t               dv_cy_reg   [0:DV_N];
    logic signed [32:0] dv_cz_reg   [0:DV_N];

    logic [61:0]        dv_rx_next [0:DV_N-1];
    logic [61:0]        dv_ry_next [0:DV_N-1];
    logic [61:0]        dv_rz_next [0:DV_N-1];
    logic [30:0]        dv_qx_next [0:DV_N-1];
    logic [30:0]        dv_qy_next [0:DV_N-1];
    logic [30:0]        dv_qz_next [0:DV_N-1];
    q30_t               dv_cx_next [0:DV_N-1];
    q30_t               dv_cy_next [0:DV_N-1];
    logic signed [32:0] dv_cz_next [0:DV_N-1];

    always_comb
    begin
        logic [62:0]        dsh;
        q30_t               dx;
        q30_t               dy;
        logic signed [32:0] at;
        for (int j = 0; j < DV_N; j++)
        begin
            dsh = 63'(dv_d_reg[j]) << (DV_N - 1 - j);
            dv_rx_next[j] = dv_rx_reg[j];
            dv_ry_next[j] = dv_ry_reg[j];
            dv_rz_next[j] = dv_rz_reg[j];
            dv_qx_next[j] = dv_qx_reg[j];
            dv_qy_next[j] = dv_qy_reg[j];
            dv_qz_next[j] = dv_qz_reg[j];
            if ({1'b0, dv_rx_reg[j]} >= dsh)
            begin
                dv_rx_next[j] = dv_rx_reg[j] - dsh[61:0];
                dv_qx_next[j][DV_N - 1 - j] = 1'b1;
            end
            if ({1'b0, dv_ry_reg[j]} >= dsh)
            begin
                dv_ry_next[j] = dv_ry_reg[j] - dsh[61:0];
                dv_qy_next[j][DV_N - 1 - j] = 1'b1;
            end
            if ({1'b0, dv_rz_reg[j]} >= dsh)
            begin
                dv_rz_next[j] = dv_rz_reg[j] - dsh[61:0];
                dv_qz_next[j][DV_N - 1 - j] = 1'b1;
            end

            dv_cx_next[j] = dv_cx_reg[j];
            dv_cy_next[j] = dv_cy_reg[j];
            dv_cz_next[j] = dv_cz_reg[j];
            dx = dv_cy_reg[j] >>> j;
            dy = dv_cx_reg[j] >>> j;
            at = 33'(ATAN_TAB[(j < CORDIC_MAX) ? j : 0]);
            if (j < NC)
            begin
                if (!dv_cz_reg[j][32])
                begin
                    dv_cx_next[j] = dv_cx_reg[j] - dx;
                    dv_cy_next[j] = dv_cy_reg[j] + dy;
                    dv_cz_next[j] = dv_cz_reg[j] - at;
                end
                else
                begin
                    dv_cx_next[j] = dv_cx_reg[j] + dx;
                    dv_cy_next[j] = dv_cy_reg[j] - dy;
                    dv_cz_next[j] = dv_cz_reg[j] + at;
                end
            end
        end
    end

    // sign and quadrant stage
    logic               sg_v_reg, sg_zero_reg;
    logic signed [31:0] sg_ux_reg, sg_uy_reg, sg_uz_reg;
    q30_t               sg_c_reg, sg_s_reg;
    q30_t               sg_c_next, sg_s_next;

    always_comb
    begin
        case (dv_quad_reg[DV_N])
            QUAD_0:
            begin
                sg_c_next = dv_cx_reg[DV_N];
                sg_s_next = dv_cy_reg[DV_N];
            end
            QUAD_1:
            begin
                sg_c_next = -dv_cy_reg[DV_N];
                sg_s_next = dv_cx_reg[DV_N];
            end
            QUAD_2:
            begin
                sg_c_next = -dv_cx_reg[DV_N];
                sg_s_next = -dv_cy_reg[DV_N];
            end
            default:
            begin
                sg_c_next = dv_cy_reg[DV_N];
                sg_s_next = -dv_cx_reg[DV_N];
            end
        endcase
    end

    // product stages
    logic m1_v_reg, m1_zero_reg, m2_v_reg, m2_zero_reg;
    q30_t m1_xx_reg, m1_yy_reg, m1_zz_reg, m1_xy_reg, m1_yz_reg, m1_zx_reg;
    q30_t m1_xs_reg, m1_ys_reg, m1_zs_reg, m1_c_reg, m1_nc_reg;
    q30_t m2_xx_reg, m2_yy_reg, m2_zz_reg, m2_xy_reg, m2_yz_reg, m2_zx_reg;
    q30_t m2_xs_reg, m2_ys_reg, m2_zs_reg, m2_c_reg;
    q30_t ux, uy, uz;

    assign ux = 34'(sg_ux_reg);
    assign uy = 34'(sg_uy_reg);
    assign uz = 34'(sg_uz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            for (int k = 0; k <= SQ_N; k++)
                sq_v_reg[k] <= 1'b0;
            for (int j = 0; j <= DV_N; j++)
                dv_v_reg[j] <= 1'b0;
            sg_v_reg      <= 1'b0;
            m1_v_reg      <= 1'b0;
            m2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg      <= in_valid;
            v1_reg      <= v0_reg;
            sq_v_reg[0] <= v1_reg;
            for (int k = 0; k < SQ_N; k++)
                sq_v_reg[k+1] <= sq_v_reg[k];
            dv_v_reg[0] <= sq_v_reg[SQ_N];
            for (int j = 0; j < DV_N; j++)
                dv_v_reg[j+1] <= dv_v_reg[j];
            sg_v_reg      <= dv_v_reg[DV_N];
            m1_v_reg      <= sg_v_reg;
            m2_v_reg      <= m1_v_reg;
            out_valid_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang0_reg <= angle;
            ax0_reg  <= axis_x;
            ay0_reg  <= axis_y;
            az0_reg  <= axis_z;

            ang1_reg <= ang0_reg;
            ax1_reg  <= ax0_reg;
            ay1_reg  <= ay0_reg;
            az1_reg  <= az0_reg;
            sqx1_reg <= px[30:0];
            sqy1_reg <= py[30:0];
            sqz1_reg <= pz[30:0];

            sq_op_reg[0]   <= {n2_sum, 32'd0};
            sq_res_reg[0]  <= 64'd0;
            sq_zero_reg[0] <= (n2_sum == 32'd0);
            sq_ang_reg[0]  <= ang1_reg;
            sq_ax_reg[0]   <= ax1_reg;
            sq_ay_reg[0]   <= ay1_reg;
            sq_az_reg[0]   <= az1_reg;
            for (int k = 0; k < SQ_N; k++)
            begin
                sq_op_reg[k+1]   <= sq_op_next[k];
                sq_res_reg[k+1]  <= sq_res_next[k];
                sq_zero_reg[k+1] <= sq_zero_reg[k];
                sq_ang_reg[k+1]  <= sq_ang_reg[k];
                sq_ax_reg[k+1]   <= sq_ax_reg[k];
                sq_ay_reg[k+1]   <= sq_ay_reg[k];
                sq_az_reg[k+1]   <= sq_az_reg[k];
            end

            dv_zero_reg[0] <= sq_zero_reg[SQ_N];
            dv_d_reg[0]    <= len;
            dv_rx_reg[0]   <= {abs16(sq_ax_reg[SQ_N]), 46'd0} + 62'(len >> 1);
            dv_ry_reg[0]   <= {abs16(sq_ay_reg[SQ_N]), 46'd0} + 62'(len >> 1);
            dv_rz_reg[0]   <= {abs16(sq_az_reg[SQ_N]), 46'd0} + 62'(len >> 1);
            dv_qx_reg[0]   <= 31'd0;
            dv_qy_reg[0]   <= 31'd0;
            dv_qz_reg[0]   <= 31'd0;
            dv_sx_reg[0]   <= sq_ax_reg[SQ_N][15];
            dv_sy_reg[0]   <= sq_ay_reg[SQ_N][15];
            dv_sz_reg[0]   <= sq_az_reg[SQ_N][15];
            dv_quad_reg[0] <= quad_t'(sq_ang_reg[SQ_N][15:14]);
            dv_cx_reg[0]   <= CORDIC_INV_GAIN;
            dv_cy_reg[0]   <= '0;
            dv_cz_reg[0]   <= signed'({3'b000, sq_ang_reg[SQ_N][13:0], 16'd0});
            for (int j = 0; j < DV_N; j++)
            begin
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                dv_d_reg[j+1]    <= dv_d_reg[j];
                dv_rx_reg[j+1]   <= dv_rx_next[j];
                dv_ry_reg[j+1]   <= dv_ry_next[j];
                dv_rz_reg[j+1]   <= dv_rz_next[j];
                dv_qx_reg[j+1]   <= dv_qx_next[j];
                dv_qy_reg[j+1]   <= dv_qy_next[j];
                dv_qz_reg[j+1]   <= dv_qz_next[j];
                dv_sx_reg[j+1]   <= dv_sx_reg[j];
                dv_sy_reg[j+1]   <= dv_sy_reg[j];
                dv_sz_reg[j+1]   <= dv_sz_reg[j];
                dv_quad_reg[j+1] <= dv_quad_reg[j];
                dv_cx_reg[j+1]   <= dv_cx_next[j];
                dv_cy_reg[j+1]   <= dv_cy_next[j];
                dv_cz_reg[j+1]   <= dv_cz_next[j];
            end

            sg_zero_reg <= dv_zero_reg[DV_N];
            sg_ux_reg   <= dv_sx_reg[DV_N] ? -signed'({1'b0, dv_qx_reg[DV_N]})
                                           :  signed'({1'b0, dv_qx_reg[DV_N]});
            sg_uy_reg   <= dv_sy_reg[DV_N] ? -signed'({1'b0, dv_qy_reg[DV_N]})
                                           :  signed'({1'b0, dv_qy_reg[DV_N]});
            sg_uz_reg   <= dv_sz_reg[DV_N] ? -signed'({1'b0, dv_qz_reg[DV_N]})
                                           :  signed'({1'b0, dv_qz_reg[DV_N]});
            sg_c_reg    <= sg_c_next;
            sg_s_reg    <= sg_s_next;

            m1_zero_reg <= sg_zero_reg;
            m1_xx_reg   <= mul30(ux, ux);
            m1_yy_reg   <= mul30(uy, uy);
            m1_zz_reg   <= mul30(uz, uz);
            m1_xy_reg   <= mul30(ux, uy);
            m1_yz_reg   <= mul30(uy, uz);
            m1_zx_reg   <= mul30(uz, ux);
            m1_xs_reg   <= mul30(ux, sg_s_reg);
            m1_ys_reg   <= mul30(uy, sg_s_reg);
            m1_zs_reg   <= mul30(uz, sg_s_reg);
            m1_c_reg    <= sg_c_reg;
            m1_nc_reg   <= Q30_ONE - sg_c_reg;

            m2_zero_reg <= m1_zero_reg;
            m2_xx_reg   <= mul30(m1_xx_reg, m1_nc_reg);
            m2_yy_reg   <= mul30(m1_yy_reg, m1_nc_reg);
            m2_zz_reg   <= mul30(m1_zz_reg, m1_nc_reg);
            m2_xy_reg   <= mul30(m1_xy_reg, m1_nc_reg);
            m2_yz_reg   <= mul30(m1_yz_reg, m1_nc_reg);
            m2_zx_reg   <= mul30(m1_zx_reg, m1_nc_reg);
            m2_xs_reg   <= m1_xs_reg;
            m2_ys_reg   <= m1_ys_reg;
            m2_zs_reg   <= m1_zs_reg;
            m2_c_reg    <= m1_c_reg;

            zero_axis_reg <= m2_zero_reg;
            r00_reg <= m2_zero_reg ? OUT_MAX : to_out(36'(m2_xx_reg) + 36'(m2_c_reg));
            r01_reg <= m2_zero_reg ? '0 : to_out(36'(m2_xy_reg) - 36'(m2_zs_reg));
            r02_reg <= m2_zero_reg ? '0 : to_out(36'(m2_zx_reg) + 36'(m2_ys_reg));
            r10_reg <= m2_zero_reg ? '0 : to_out(36'(m2_xy_reg) + 36'(m2_zs_reg));
            r11_reg <= m2_zero_reg ? OUT_MAX : to_out(36'(m2_yy_reg) + 36'(m2_c_reg));
            r12_reg <= m2_zero_reg ? '0 : to_out(36'(m2_yz_reg) - 36'(m2_xs_reg));
            r20_reg <= m2_zero_reg ? '0 : to_out(36'(m2_zx_reg) - 36'(m2_ys_reg));
            r21_reg <= m2_zero_reg ? '0 : to_out(36'(m2_yz_reg) + 36'(m2_xs_reg));
            r22_reg <= m2_zero_reg ? OUT_MAX : to_out(36'(m2_zz_reg) + 36'(m2_c_reg));
        end
    end

    assign out_valid = out_valid_reg;
    assign zero_axis = zero_axis_reg;
    assign r00       = r00_reg;
    assign r01       = r01_reg;
    assign r02       = r02_reg;
    assign r10       = r10_reg;
    assign r11       = r11_reg;
    assign r12       = r12_reg;
    assign r20       = r20_reg;
    assign r21       = r21_reg;
    assign r22       = r22_reg;

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> in_stall)
        else $error("input taken while output is blocked");

    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zero_axis_reg) |->
            (r00_reg == OUT_MAX && r11_reg == OUT_MAX && r22_reg == OUT_MAX &&
             r01_reg == 18'sd0 && r12_reg == 18'sd0 && r20_reg == 18'sd0))
        else $error("zero axis word is not the identity");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_v_reg[SQ_N] && !sq_zero_reg[SQ_N]) |-> (sq_res_reg[SQ_N][31:16] != 16'd0))
        else $error("axis length below one for a nonzero axis");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (r01_reg <= OUT_MAX && r01_reg >= -OUT_MAX &&
                           r00_reg <= OUT_MAX && r00_reg >= -OUT_MAX))
        else $error("matrix element out of range");

endmodule
